/* hw/rtl/bitmap_rle_token_decoder_assert.svh */
// Assertion macros for the bitmap run-length token decoder.
`ifndef BITMAP_RLE_TOKEN_DECODER_ASSERT_SVH
`define BITMAP_RLE_TOKEN_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define BRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checks that a consequent holds in the cycle after its antecedent.
`define BRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRE_ASSERT(lbl, clk, rstn, prop, msg)
`define BRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/bre_pkg.sv */
// Types and constants of the bitmap run-length token decoder.
package bre_pkg;

  // Parser phases of the run-length grammar.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_RIGHT   = 3'd3,
    PH_DOWN    = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  // Token kinds on the output channel.
  typedef enum logic [2:0] {
    TK_RUN     = 3'd0,
    TK_LITERAL = 3'd1,
    TK_EOL     = 3'd2,
    TK_EOB     = 3'd3,
    TK_DELTA   = 3'd4
  } token_kind_e;

  // Escape codes that follow a zero byte.
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;

  // One decoded token.
  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] run_length;
    logic [7:0] first_pixel;
    logic [3:0] second_pixel;
    logic [7:0] delta_right;
    logic [7:0] delta_down;
  } token_t;

endpackage

/* hw/rtl/bre_stream_if.sv */
// Valid/ready channel interfaces for input bytes and output tokens.
interface bre_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface bre_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] run_length;
  logic [7:0] first_pixel;
  logic [3:0] second_pixel;
  logic [7:0] delta_right;
  logic [7:0] delta_down;

  modport source (output valid, output token_kind, output run_length, output first_pixel,
                  output second_pixel, output delta_right, output delta_down, input ready);
  modport sink (input valid, input token_kind, input run_length, input first_pixel,
                input second_pixel, input delta_right, input delta_down, output ready);
endinterface

/* hw/rtl/bre_parser.sv */
// Run-length grammar parser: phase state and token formation for one byte.
`include "bitmap_rle_token_decoder_assert.svh"
module bre_parser import bre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       nib_mode_i,
  output logic       tok_valid_o,
  output token_t     tok_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] pending_count_q, pending_count_d;
  logic [7:0] literal_left_q, literal_left_d;
  logic       pad_pending_q, pad_pending_d;
  logic [7:0] held_right_q, held_right_d;

  logic [7:0] hi_nib;
  logic [7:0] lo_nib;
  logic [8:0] count_plus_one;
  logic [7:0] left_after;

  assign hi_nib         = (byte_i & NIB_HI_MASK) >> 4;
  assign lo_nib         = byte_i & NIB_LO_MASK;
  assign count_plus_one = {1'b0, byte_i} + 9'd1;

  // Pixels left in a literal run after this byte.
  always_comb begin
    if (!nib_mode_i) begin
      left_after = literal_left_q - 8'd1;
    end else if (literal_left_q >= 8'd2) begin
      left_after = literal_left_q - 8'd2;
    end else begin
      left_after = 8'd0;
    end
  end

  // Next phase and held state.
  always_comb begin
    phase_d         = phase_q;
    pending_count_d = pending_count_q;
    literal_left_d  = literal_left_q;
    pad_pending_d   = pad_pending_q;
    held_right_d    = held_right_q;
    case (phase_q)
      PH_IDLE: begin
        if (byte_i == 8'd0) begin
          phase_d = PH_ESCAPE;
        end else begin
          pending_count_d = byte_i;
          phase_d         = PH_VALUE;
        end
      end
      PH_VALUE: phase_d = PH_IDLE;
      PH_ESCAPE: begin
        if (byte_i == ESC_EOL) begin
          phase_d = PH_IDLE;
        end else if (byte_i == ESC_EOB) begin
          phase_d = PH_DONE;
        end else if (byte_i == ESC_DELTA) begin
          phase_d = PH_RIGHT;
        end else begin
          // A literal run pads to a word when it fills an odd number of bytes.
          literal_left_d = byte_i;
          pad_pending_d  = nib_mode_i ? count_plus_one[1] : byte_i[0];
          phase_d        = PH_LITERAL;
        end
      end
      PH_RIGHT: begin
        held_right_d = byte_i;
        phase_d      = PH_DOWN;
      end
      PH_DOWN: phase_d = PH_IDLE;
      PH_LITERAL: begin
        literal_left_d = left_after;
        if (left_after == 8'd0) begin
          phase_d = pad_pending_q ? PH_PAD : PH_IDLE;
        end
      end
      PH_PAD: begin
        pad_pending_d = 1'b0;
        phase_d       = PH_IDLE;
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // Token formed by this byte.
  always_comb begin
    tok_valid_o = 1'b0;
    tok_o       = '0;
    case (phase_q)
      PH_VALUE: begin
        tok_valid_o      = 1'b1;
        tok_o.token_kind = TK_RUN;
        tok_o.run_length = pending_count_q;
        if (nib_mode_i) begin
          tok_o.first_pixel  = hi_nib;
          tok_o.second_pixel = lo_nib[3:0];
        end else begin
          tok_o.first_pixel = byte_i;
        end
      end
      PH_ESCAPE: begin
        if (byte_i == ESC_EOL) begin
          tok_valid_o      = 1'b1;
          tok_o.token_kind = TK_EOL;
        end else if (byte_i == ESC_EOB) begin
          tok_valid_o      = 1'b1;
          tok_o.token_kind = TK_EOB;
        end
      end
      PH_DOWN: begin
        tok_valid_o       = 1'b1;
        tok_o.token_kind  = TK_DELTA;
        tok_o.delta_right = held_right_q;
        tok_o.delta_down  = byte_i;
      end
      PH_LITERAL: begin
        tok_valid_o      = 1'b1;
        tok_o.token_kind = TK_LITERAL;
        if (!nib_mode_i) begin
          tok_o.run_length  = 8'd1;
          tok_o.first_pixel = byte_i;
        end else if (literal_left_q >= 8'd2) begin
          tok_o.run_length   = 8'd2;
          tok_o.first_pixel  = hi_nib;
          tok_o.second_pixel = lo_nib[3:0];
        end else begin
          // Odd tail of a nibble literal: only the high nibble carries a pixel.
          tok_o.run_length  = 8'd1;
          tok_o.first_pixel = hi_nib;
        end
      end
      default: tok_valid_o = 1'b0;
    endcase
  end

  // Parser state registers advance once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      pending_count_q <= '0;
      literal_left_q  <= '0;
      pad_pending_q   <= 1'b0;
      held_right_q    <= '0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      pending_count_q <= pending_count_d;
      literal_left_q  <= literal_left_d;
      pad_pending_q   <= pad_pending_d;
      held_right_q    <= held_right_d;
    end
  end

  `BRE_ASSERT_NEXT(a_done_sticks, clk_i, rst_ni, phase_q == PH_DONE, phase_q == PH_DONE, "parser left the end-of-bitmap phase")
  `BRE_ASSERT(a_literal_nonzero, clk_i, rst_ni, (phase_q != PH_LITERAL) || (literal_left_q != 8'd0), "literal phase with no pixels left")
  `BRE_ASSERT(a_pad_only_when_pending, clk_i, rst_ni, (phase_q != PH_PAD) || pad_pending_q, "pad phase without a pending pad")

endmodule

/* hw/rtl/bre_out_reg.sv */
// Output token register that drives the result channel.
module bre_out_reg import bre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic        tok_valid_i,
  input  token_t      tok_i,
  output logic        can_load_o,
  bre_token_if.source tok_o
);

  logic   valid_q, valid_d;
  token_t tok_q;

  // The register takes a new step whenever it is empty or being drained.
  assign can_load_o = !valid_q || tok_o.ready;

  always_comb begin
    if (load_i) begin
      valid_d = tok_valid_i;
    end else begin
      valid_d = valid_q && !tok_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i && tok_valid_i) begin
      tok_q <= tok_i;
    end
  end

  assign tok_o.valid        = valid_q;
  assign tok_o.token_kind   = tok_q.token_kind;
  assign tok_o.run_length   = tok_q.run_length;
  assign tok_o.first_pixel  = tok_q.first_pixel;
  assign tok_o.second_pixel = tok_q.second_pixel;
  assign tok_o.delta_right  = tok_q.delta_right;
  assign tok_o.delta_down   = tok_q.delta_down;

endmodule

/* hw/rtl/bitmap_rle_token_decoder.sv */
// A byte request is registered, parsed and its token registered before it reaches the output.
// Throughput: one byte per cycle; the output token register only stalls input when it is
// full and the consumer is not ready.
// Bytes that end in padding or escape prefixes yield no token and free the slot at once.
// Reset (asynchronous, active low) clears the parser to idle, the mode to 8-bit runs and
// empties both pipeline registers.
module bitmap_rle_token_decoder import bre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  bre_byte_if.sink    req_i,
  bre_token_if.source tok_o
);

  logic       rle_mode_q;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       can_load;
  logic       step;
  logic       accept;
  logic       tok_valid;
  token_t     tok;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      rle_mode_q <= cfg_wdata_i;
    end
  end

  // Input byte register.
  assign step        = in_valid_q && can_load;
  assign req_i.ready = !in_valid_q || can_load;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= req_i.data_byte;
    end
  end

  bre_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .nib_mode_i (rle_mode_q),
    .tok_valid_o(tok_valid),
    .tok_o      (tok)
  );

  bre_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .tok_valid_i(tok_valid),
    .tok_i      (tok),
    .can_load_o (can_load),
    .tok_o      (tok_o)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the bitmap run-length token decoder.
`timescale 1ns / 1ps

module testbench;
  import bre_pkg::*;

  localparam int          IDLE_LIMIT    = 5000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          PHASE_ITEMS   = 170;
  localparam int          RANDOM_PHASES = 6;
  localparam token_t      NO_TOKEN      = '0;

  // Stall styles of the token receiver.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_MOSTLY
  } rx_style_e;

  // One row of the directed stimulus table.
  typedef struct {
    logic       mode;
    logic [7:0] data;
    bit         has_want;
    token_t     want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  bre_byte_if  byte_bus ();
  bre_token_if tok_bus ();

  bitmap_rle_token_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (byte_bus),
    .tok_o       (tok_bus)
  );

  always #5 clk_i = ~clk_i;

  // Predicted parser state and mode.
  logic       cur_mode;
  phase_e     parse_state;
  logic [7:0] run_count;
  logic [7:0] lit_remaining;
  logic       pad_due;
  logic [7:0] skip_right;

  token_t pending_tokens[$];
  int     n_fail;
  int     n_sent;
  int     n_cfg_writes;
  int     n_tokens;
  int     kind_seen[5];
  int     burst_left;
  int     idle_cycles;

  function automatic token_t make_token(input token_kind_e kind, input logic [7:0] len,
                                        input logic [7:0] p1, input logic [3:0] p2,
                                        input logic [7:0] dr, input logic [7:0] dd);
    token_t t;
    t.token_kind   = kind;
    t.run_length   = len;
    t.first_pixel  = p1;
    t.second_pixel = p2;
    t.delta_right  = dr;
    t.delta_down   = dd;
    return t;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when the byte yields a token.
  function automatic bit decode_byte(input logic [7:0] b, output token_t t);
    logic [3:0] hi;
    logic [3:0] lo;
    logic       nib;
    int         half;
    hi   = 4'((b & NIB_HI_MASK) >> 4);
    lo   = 4'(b & NIB_LO_MASK);
    nib  = cur_mode;
    half = (int'(b) + 1) / 2;
    t    = NO_TOKEN;
    case (parse_state)
      PH_IDLE: begin
        if (b == 8'd0) begin
          parse_state = PH_ESCAPE;
        end else begin
          run_count   = b;
          parse_state = PH_VALUE;
        end
        return 1'b0;
      end
      PH_VALUE: begin
        parse_state = PH_IDLE;
        if (nib) t = make_token(TK_RUN, run_count, {4'd0, hi}, lo, 8'd0, 8'd0);
        else t = make_token(TK_RUN, run_count, b, 4'd0, 8'd0, 8'd0);
        return 1'b1;
      end
      PH_ESCAPE: begin
        if (b == ESC_EOL) begin
          parse_state = PH_IDLE;
          t = make_token(TK_EOL, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0);
          return 1'b1;
        end
        if (b == ESC_EOB) begin
          parse_state = PH_DONE;
          t = make_token(TK_EOB, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0);
          return 1'b1;
        end
        if (b == ESC_DELTA) begin
          parse_state = PH_RIGHT;
          return 1'b0;
        end
        // Literal run: the pad decision is fixed by the mode at the count byte.
        lit_remaining = b;
        pad_due       = nib ? half[0] : b[0];
        parse_state   = PH_LITERAL;
        return 1'b0;
      end
      PH_RIGHT: begin
        skip_right  = b;
        parse_state = PH_DOWN;
        return 1'b0;
      end
      PH_DOWN: begin
        parse_state = PH_IDLE;
        t = make_token(TK_DELTA, 8'd0, 8'd0, 4'd0, skip_right, b);
        return 1'b1;
      end
      PH_LITERAL: begin
        if (!nib) begin
          t = make_token(TK_LITERAL, 8'd1, b, 4'd0, 8'd0, 8'd0);
          lit_remaining = lit_remaining - 8'd1;
        end else if (lit_remaining >= 8'd2) begin
          t = make_token(TK_LITERAL, 8'd2, {4'd0, hi}, lo, 8'd0, 8'd0);
          lit_remaining = lit_remaining - 8'd2;
        end else begin
          // Odd nibble count: the low nibble of the last byte is dropped.
          t = make_token(TK_LITERAL, 8'd1, {4'd0, hi}, 4'd0, 8'd0, 8'd0);
          lit_remaining = 8'd0;
        end
        if (lit_remaining == 8'd0) parse_state = pad_due ? PH_PAD : PH_IDLE;
        return 1'b1;
      end
      PH_PAD: begin
        pad_due     = 1'b0;
        parse_state = PH_IDLE;
        return 1'b0;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Sends one byte request in bursts with random gaps; called and returns at a falling edge.
  task automatic push_byte(input logic [7:0] b, input bit has_want = 1'b0,
                           input token_t want = NO_TOKEN);
    int     gap;
    token_t got;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(64, 200);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 32);
        gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap > 0) begin
        byte_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    do @(posedge clk_i); while (!byte_bus.ready);
    n_sent++;
    if (decode_byte(b, got)) pending_tokens.push_back(has_want ? want : got);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Writes the mode register once the decoder has drained.
  task automatic write_mode(input logic m);
    byte_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_tokens.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
    n_cfg_writes++;
  endtask

  // Sends one grammar sequence with random content, or a little noise.
  task automatic emit_sequence();
    int         pick;
    int         count;
    int         nbytes;
    logic [7:0] b;
    // Bring the parser back to the idle phase so the sequence lines up with the grammar
    // and no stray byte can end the bitmap.
    while (parse_state != PH_IDLE) begin
      push_byte((parse_state == PH_ESCAPE) ? ESC_EOL : 8'($urandom_range(0, 255)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 9))
        0:       count = 1;
        1:       count = 255;
        2, 3:    count = $urandom_range(1, 255);
        default: count = $urandom_range(1, 16);
      endcase
      push_byte(8'(count));
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 45) begin
      push_byte(8'd0);
      push_byte(ESC_EOL);
    end else if (pick < 58) begin
      push_byte(8'd0);
      push_byte(ESC_DELTA);
      push_byte(8'($urandom_range(0, 255)));
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      case ($urandom_range(0, 19))
        0:       count = 3;
        1:       count = 255;
        2, 3:    count = $urandom_range(21, 254);
        default: count = $urandom_range(3, 20);
      endcase
      nbytes = cur_mode ? (count + 1) / 2 : count;
      push_byte(8'd0);
      push_byte(8'(count));
      repeat (nbytes) push_byte(8'($urandom_range(0, 255)));
      if (nbytes % 2 == 1) push_byte(8'($urandom_range(0, 255)));
    end else begin
      // Noise bytes, kept clear of end of bitmap so the stream stays alive.
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (parse_state == PH_ESCAPE && b == ESC_EOB) b = ESC_EOL;
        push_byte(b);
      end
    end
  endtask

  // Token receiver with its own stall pattern.
  initial begin : token_receiver
    int        cyc;
    rx_style_e style;
    cyc   = 0;
    style = RX_ALWAYS;
    tok_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) style = rx_style_e'($urandom_range(0, 3));
      case (style)
        RX_ALWAYS: tok_bus.ready <= 1'b1;
        RX_RANDOM: tok_bus.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: tok_bus.ready <= (cyc % 3 == 0);
        default:   tok_bus.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // Compares each accepted token with the oldest expectation.
  always @(posedge clk_i) begin : token_check
    token_t want;
    if (rst_ni && tok_bus.valid && tok_bus.ready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: kind %0d", tok_bus.token_kind);
        n_fail++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 8'(want.token_kind), 8'(tok_bus.token_kind));
        check_field("run_length", want.run_length, tok_bus.run_length);
        check_field("first_pixel", want.first_pixel, tok_bus.first_pixel);
        check_field("second_pixel", 8'(want.second_pixel), 8'(tok_bus.second_pixel));
        check_field("delta_right", want.delta_right, tok_bus.delta_right);
        check_field("delta_down", want.delta_down, tok_bus.delta_down);
        if (want.token_kind < 3'd5) kind_seen[want.token_kind]++;
        n_tokens++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if ((byte_bus.valid && byte_bus.ready) || (tok_bus.valid && tok_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [27];
    int       target;
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = 8'd0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 1'b0;
    rst_ni             = 1'b0;
    idle_cycles        = 0;
    n_fail             = 0;
    n_sent             = 0;
    n_cfg_writes       = 0;
    n_tokens           = 0;
    burst_left         = 0;
    kind_seen          = '{default: 0};
    cur_mode           = 1'b0;
    parse_state        = PH_IDLE;
    run_count          = 8'd0;
    lit_remaining      = 8'd0;
    pad_due            = 1'b0;
    skip_right         = 8'd0;

    // Directed rows: extremes of runs and deltas, literal padding, nibble mode and
    // a mode change in the middle of a nibble literal run.
    dir_rows = '{
      '{1'b0, 8'h01, 1'b0, NO_TOKEN},
      '{1'b0, 8'hFF, 1'b1, make_token(TK_RUN, 8'd1, 8'hFF, 4'd0, 8'd0, 8'd0)},
      '{1'b0, 8'hFF, 1'b0, NO_TOKEN},
      '{1'b0, 8'h00, 1'b1, make_token(TK_RUN, 8'd255, 8'h00, 4'd0, 8'd0, 8'd0)},
      '{1'b0, 8'h00, 1'b0, NO_TOKEN},
      '{1'b0, ESC_EOL, 1'b1, make_token(TK_EOL, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0)},
      '{1'b0, 8'h00, 1'b0, NO_TOKEN},
      '{1'b0, ESC_DELTA, 1'b0, NO_TOKEN},
      '{1'b0, 8'hFF, 1'b0, NO_TOKEN},
      '{1'b0, 8'h00, 1'b1, make_token(TK_DELTA, 8'd0, 8'd0, 4'd0, 8'hFF, 8'h00)},
      '{1'b0, 8'h00, 1'b0, NO_TOKEN},
      '{1'b0, 8'h03, 1'b0, NO_TOKEN},
      '{1'b0, 8'hA5, 1'b1, make_token(TK_LITERAL, 8'd1, 8'hA5, 4'd0, 8'd0, 8'd0)},
      '{1'b0, 8'h5A, 1'b0, NO_TOKEN},
      '{1'b0, 8'h00, 1'b1, make_token(TK_LITERAL, 8'd1, 8'h00, 4'd0, 8'd0, 8'd0)},
      '{1'b0, 8'h77, 1'b0, NO_TOKEN},
      '{1'b1, 8'h05, 1'b0, NO_TOKEN},
      '{1'b1, 8'h3C, 1'b1, make_token(TK_RUN, 8'd5, 8'h03, 4'hC, 8'd0, 8'd0)},
      '{1'b1, 8'h00, 1'b0, NO_TOKEN},
      '{1'b1, 8'h03, 1'b0, NO_TOKEN},
      '{1'b1, 8'hAB, 1'b1, make_token(TK_LITERAL, 8'd2, 8'h0A, 4'hB, 8'd0, 8'd0)},
      '{1'b1, 8'hCD, 1'b1, make_token(TK_LITERAL, 8'd1, 8'h0C, 4'd0, 8'd0, 8'd0)},
      '{1'b1, 8'h00, 1'b0, NO_TOKEN},
      '{1'b1, 8'h05, 1'b0, NO_TOKEN},
      '{1'b1, 8'h12, 1'b0, NO_TOKEN},
      '{1'b0, 8'h34, 1'b0, NO_TOKEN},
      '{1'b0, 8'hE9, 1'b0, NO_TOKEN}
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_mode(1'b0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) write_mode(dir_rows[i].mode);
      push_byte(dir_rows[i].data, dir_rows[i].has_want, dir_rows[i].want);
    end

    // Random phases alternate between nibble and byte mode.
    target = n_sent;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_mode((ph % 2 == 0) ? 1'b1 : 1'b0);
      target += PHASE_ITEMS;
      while (n_sent < target) emit_sequence();
    end

    // Return to the idle phase, end the bitmap, and show that later bytes are ignored.
    while (parse_state != PH_IDLE) begin
      push_byte((parse_state == PH_ESCAPE) ? ESC_EOL : 8'($urandom_range(0, 255)));
    end
    push_byte(8'd0);
    push_byte(ESC_EOB);
    push_byte(8'h00);
    push_byte(ESC_EOL);
    push_byte(8'h07);
    push_byte(8'($urandom_range(0, 255)));
    byte_bus.valid <= 1'b0;

    while (pending_tokens.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (pending_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", pending_tokens.size());
      n_fail++;
    end

    $display("Sent %0d bytes over %0d mode writes; checked %0d tokens.",
             n_sent, n_cfg_writes, n_tokens);
    $display("Token mix: run %0d, literal %0d, end of line %0d, end of bitmap %0d, delta %0d.",
             kind_seen[TK_RUN], kind_seen[TK_LITERAL], kind_seen[TK_EOL],
             kind_seen[TK_EOB], kind_seen[TK_DELTA]);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
